>>> design/mpsa_pkg.sv
package mpsa_pkg;

  localparam int POOLS       = 8;
  localparam int ROWS        = 8;
  localparam int COLS        = 8;
  localparam int MAX_RESULTS = 64;

  localparam int POOL_W   = 3;
  localparam int COUNT_W  = 7;
  localparam int ROW_W    = 3;
  localparam int COL_W    = 3;
  localparam int FREE_W   = 7;
  localparam int STATUS_W = 2;
  localparam int CFG_W    = 4;
  localparam int ADDR_W   = $clog2(POOLS * ROWS);
  localparam int OCC_DEPTH = POOLS * ROWS;

  localparam logic [FREE_W-1:0]   FREE_RESET  = FREE_W'(ROWS * COLS);
  localparam logic [CFG_W-1:0]    POOLS_RESET = CFG_W'(5);

  localparam logic [STATUS_W-1:0] ST_GRANTED  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_POOL = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NO_ROOM  = 2'd2;

  typedef logic [COLS-1:0] row_bits_t;

  typedef struct packed {
    logic [POOL_W-1:0]  pool;
    logic [COUNT_W-1:0] count;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                seat_valid;
    logic [ROW_W-1:0]    row;
    logic [COL_W-1:0]    col;
    logic [FREE_W-1:0]   free_after;
    logic                last;
  } rsp_t;

  typedef struct packed {
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    row_bits_t         wr_data;
  } occ_cmd_t;

  function automatic logic [ADDR_W-1:0] row_addr(input logic [POOL_W-1:0] pool,
                                                 input logic [ROW_W-1:0] row);
    row_addr = ADDR_W'(int'(pool) * ROWS + int'(row));
  endfunction

  // Lowest-numbered free column of a row word.
  function automatic logic [COL_W-1:0] first_free(input row_bits_t bits);
    logic [COL_W-1:0] col;
    col = '0;
    for (int j = COLS - 1; j >= 0; j--) begin
      if (!bits[j]) col = COL_W'(j);
    end
    first_free = col;
  endfunction

endpackage

>>> design/mpsa_occ_mem.sv
module mpsa_occ_mem (
  input  logic               clk,
  input  logic               rst,
  input  mpsa_pkg::occ_cmd_t cmd,
  output mpsa_pkg::row_bits_t rd_data
);
  import mpsa_pkg::*;

  row_bits_t            ram [OCC_DEPTH];
  logic [OCC_DEPTH-1:0] written;
  row_bits_t            ram_q;
  logic                 written_q;

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      ram[cmd.wr_addr] <= cmd.wr_data;
    end
    if (cmd.rd_en) begin
      ram_q <= ram[cmd.rd_addr];
    end
  end

  // Rows never written since reset read as all free.
  always_ff @(posedge clk) begin
    if (rst) begin
      written   <= '0;
      written_q <= 1'b0;
    end else begin
      if (cmd.wr_en) written[cmd.wr_addr] <= 1'b1;
      if (cmd.rd_en) written_q <= written[cmd.rd_addr];
    end
  end

  assign rd_data = written_q ? ram_q : '0;

endmodule

>>> design/multi_pool_bitmap_seat_allocator.sv
// Rejected, zero-count and short-pool requests: one result, registered from the check state.
// Granted requests: first seat after the check, load and scan states, then one seat per cycle
// within a row unless the output stalls; each row step of the find-first-free scan reloads.
// One request at a time; the next is accepted once the last result is registered.
// Synchronous reset sets pools_in_use to 5, every pool's free count to ROWS*COLS and
// clears the per-row written flags so all seats read free; no clearing pass is needed.
module multi_pool_bitmap_seat_allocator (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         req_valid,
  output logic                         req_stall,
  input  mpsa_pkg::req_t               req,
  output logic                         rsp_valid,
  input  logic                         rsp_stall,
  output mpsa_pkg::rsp_t               rsp,
  input  logic                         cfg_we,
  input  logic [mpsa_pkg::CFG_W-1:0]   cfg_data
);
  import mpsa_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_CHECK = 2'd1;
  localparam logic [1:0] S_LOAD  = 2'd2;
  localparam logic [1:0] S_SCAN  = 2'd3;

  logic [1:0]         state, state_next;
  logic [CFG_W-1:0]   pools_in_use;
  logic [FREE_W-1:0]  free_count [POOLS];
  logic [POOL_W-1:0]  pool_q;
  logic [COUNT_W-1:0] count_q;
  logic [COUNT_W-1:0] left;
  logic [FREE_W-1:0]  after;
  logic [ROW_W-1:0]   row;
  row_bits_t          row_bits;
  row_bits_t          mem_rd_data;
  occ_cmd_t           occ_cmd;

  logic               out_free;
  logic               load_rsp;
  rsp_t               rsp_next;
  logic [FREE_W-1:0]  pool_free;
  logic               bad_pool;
  logic               no_room;
  logic [COL_W-1:0]   col_pick;
  row_bits_t          pick_mask;
  logic               row_full;

  mpsa_occ_mem u_occ_mem (
    .clk     (clk),
    .rst     (rst),
    .cmd     (occ_cmd),
    .rd_data (mem_rd_data)
  );

  assign req_stall = (state != S_IDLE);
  assign out_free  = !rsp_valid || !rsp_stall;

  assign pool_free = free_count[pool_q];
  assign bad_pool  = ({1'b0, pool_q} >= pools_in_use) || (32'(pool_q) >= POOLS);
  assign no_room   = (FREE_W'(count_q) > pool_free) || (32'(count_q) > MAX_RESULTS);
  assign col_pick  = first_free(row_bits);
  assign pick_mask = row_bits_t'(1) << col_pick;
  assign row_full  = &row_bits;

  always_comb begin
    state_next = state;
    load_rsp   = 1'b0;
    rsp_next   = '0;
    occ_cmd    = '0;
    unique case (state)
      S_IDLE: begin
        if (req_valid) state_next = S_CHECK;
      end
      S_CHECK: begin
        if (bad_pool) begin
          rsp_next.status = ST_BAD_POOL;
          rsp_next.last   = 1'b1;
          if (out_free) begin
            load_rsp   = 1'b1;
            state_next = S_IDLE;
          end
        end else if (no_room || count_q == '0) begin
          rsp_next.status     = no_room ? ST_NO_ROOM : ST_GRANTED;
          rsp_next.free_after = pool_free;
          rsp_next.last       = 1'b1;
          if (out_free) begin
            load_rsp   = 1'b1;
            state_next = S_IDLE;
          end
        end else begin
          occ_cmd.rd_en   = 1'b1;
          occ_cmd.rd_addr = row_addr(pool_q, '0);
          state_next      = S_LOAD;
        end
      end
      S_LOAD: begin
        state_next = S_SCAN;
      end
      S_SCAN: begin
        rsp_next.status     = ST_GRANTED;
        rsp_next.seat_valid = 1'b1;
        rsp_next.row        = row;
        rsp_next.col        = col_pick;
        rsp_next.free_after = after;
        rsp_next.last       = (left == COUNT_W'(1));
        occ_cmd.wr_addr     = row_addr(pool_q, row);
        if (row_full) begin
          // Write back the finished row and fetch the next one.
          occ_cmd.wr_en   = 1'b1;
          occ_cmd.wr_data = row_bits;
          occ_cmd.rd_en   = 1'b1;
          occ_cmd.rd_addr = row_addr(pool_q, row + ROW_W'(1));
          state_next      = S_LOAD;
        end else if (out_free) begin
          load_rsp = 1'b1;
          if (left == COUNT_W'(1)) begin
            occ_cmd.wr_en   = 1'b1;
            occ_cmd.wr_data = row_bits | pick_mask;
            state_next      = S_IDLE;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      rsp_valid    <= 1'b0;
      pools_in_use <= POOLS_RESET;
      for (int p = 0; p < POOLS; p++) free_count[p] <= FREE_RESET;
    end else begin
      state <= state_next;
      if (cfg_we) pools_in_use <= cfg_data;
      if (load_rsp) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      // Grant is certain here, so commit the new free count up front.
      if (state == S_CHECK && !bad_pool && !no_room && count_q != '0) begin
        free_count[pool_q] <= pool_free - FREE_W'(count_q);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_rsp) rsp <= rsp_next;
    if (state == S_IDLE && req_valid) begin
      pool_q  <= req.pool;
      count_q <= req.count;
    end
    if (state == S_CHECK) begin
      left  <= count_q;
      after <= pool_free - FREE_W'(count_q);
      row   <= '0;
    end
    if (state == S_LOAD) row_bits <= mem_rd_data;
    if (state == S_SCAN) begin
      if (row_full) begin
        row <= row + ROW_W'(1);
      end else if (out_free) begin
        row_bits <= row_bits | pick_mask;
        left     <= left - COUNT_W'(1);
      end
    end
  end

endmodule
